// File: rtl/oahs_pkg.sv
// ----------------------------------------------------------------------------
// oahs_pkg
// Shared types, codes and constants of the open-addressing hash set.
// ----------------------------------------------------------------------------
package oahs_pkg;

  // default table geometry
  localparam int SLOTS_LOG2_DEFAULT = 12;
  localparam int VALUE_BITS_DEFAULT = 32;

  // fixed field widths of the item and result beats
  localparam int KEY_W   = 32;
  localparam int SLOT_W  = 12;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 13;
  localparam int TSL_W   = 4;

  // table size register limits
  localparam logic [TSL_W-1:0] TSL_MIN   = 4'd8;
  localparam logic [TSL_W-1:0] TSL_RESET = 4'd8;

  // constant or-ed into the probe step, keeps the step odd
  localparam logic [KEY_W-1:0] STEP_OR = 32'h0101_0101;

  typedef enum logic [1:0] {
    OP_LOOKUP = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_WRITE  = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_INSERTED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_DONE      = 3'd4,
    ST_BAD_SLOT  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    SLOT_EMPTY = 2'd0,
    SLOT_LIVE  = 2'd1,
    SLOT_TOMB  = 2'd2
  } slot_state_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_PROBE,
    S_SLOT
  } fsm_state_t;

  typedef struct packed {
    op_t               op;
    logic [KEY_W-1:0]  key;
    logic [SLOT_W-1:0] slot;
    logic [DATA_W-1:0] value_in;
  } item_t;

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot_out;
    logic [DATA_W-1:0]  value_out;
    logic [COUNT_W-1:0] entry_count;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    accept;
    logic    clr_start;
    logic    clr_step;
    logic    probe_next;
    logic    wr_insert;
    logic    wr_delete;
    logic    wr_value;
    logic    emit;
    status_t res_status;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    op_t         op;
    op_t         item_op;     // op of the beat on the input ports
    slot_state_t rd_state;
    logic        key_match;
    logic        probe_last;
    logic        over_half;
    logic        have_tomb;
    logic        slot_ok;
    logic        clr_last;
    logic        live_zero;
  } ctrl_status_t;

endpackage

// File: rtl/oahs_ram.sv
// ----------------------------------------------------------------------------
// oahs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module oahs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/oahs_ctrl.sv
// ----------------------------------------------------------------------------
// oahs_ctrl
// Sequencer of the hash set: clearing pass, probe loop, slot operations.
// ----------------------------------------------------------------------------
module oahs_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic                  cfg_wr_en,
  input  oahs_pkg::ctrl_status_t sts,
  output oahs_pkg::ctrl_cmd_t    cmd,
  output logic                  busy
);

  oahs_pkg::fsm_state_t state;
  oahs_pkg::fsm_state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= oahs_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      oahs_pkg::S_CLEAR: begin
        if (sts.clr_last) state_next = oahs_pkg::S_IDLE;
      end
      oahs_pkg::S_IDLE: begin
        if (start) begin
          if (sts.item_op == oahs_pkg::OP_DELETE || sts.item_op == oahs_pkg::OP_WRITE) begin
            state_next = oahs_pkg::S_SLOT;
          end else begin
            state_next = oahs_pkg::S_PROBE;
          end
        end
      end
      oahs_pkg::S_PROBE: begin
        if (!cmd.probe_next) state_next = oahs_pkg::S_IDLE;
      end
      oahs_pkg::S_SLOT: begin
        state_next = oahs_pkg::S_IDLE;
      end
      default: state_next = oahs_pkg::S_CLEAR;
    endcase
    // accepted size write restarts the clearing pass
    if (cmd.clr_start) state_next = oahs_pkg::S_CLEAR;
  end

  // command outputs
  always_comb begin
    cmd.accept     = 1'b0;
    cmd.clr_start  = cfg_wr_en && sts.live_zero;
    cmd.clr_step   = 1'b0;
    cmd.probe_next = 1'b0;
    cmd.wr_insert  = 1'b0;
    cmd.wr_delete  = 1'b0;
    cmd.wr_value   = 1'b0;
    cmd.emit       = 1'b0;
    cmd.res_status = oahs_pkg::ST_FOUND;
    unique case (state)
      oahs_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
      end
      oahs_pkg::S_IDLE: begin
        cmd.accept = start && !cmd.clr_start;
      end
      oahs_pkg::S_PROBE: begin
        if (sts.rd_state == oahs_pkg::SLOT_LIVE && sts.key_match) begin
          // key hit
          cmd.emit       = 1'b1;
          cmd.res_status = oahs_pkg::ST_FOUND;
        end else if (sts.rd_state == oahs_pkg::SLOT_EMPTY || sts.probe_last) begin
          // probe sequence ended without a hit
          cmd.emit = 1'b1;
          if (sts.op == oahs_pkg::OP_LOOKUP) begin
            cmd.res_status = oahs_pkg::ST_NOT_FOUND;
          end else if (sts.over_half ||
                       (sts.rd_state != oahs_pkg::SLOT_EMPTY && !sts.have_tomb)) begin
            cmd.res_status = oahs_pkg::ST_FULL;
          end else begin
            cmd.wr_insert  = 1'b1;
            cmd.res_status = oahs_pkg::ST_INSERTED;
          end
        end else begin
          cmd.probe_next = 1'b1;
        end
      end
      oahs_pkg::S_SLOT: begin
        cmd.emit = 1'b1;
        if (!sts.slot_ok || sts.rd_state != oahs_pkg::SLOT_LIVE) begin
          cmd.res_status = oahs_pkg::ST_BAD_SLOT;
        end else begin
          cmd.res_status = oahs_pkg::ST_DONE;
          cmd.wr_delete  = (sts.op == oahs_pkg::OP_DELETE);
          cmd.wr_value   = (sts.op != oahs_pkg::OP_DELETE);
        end
      end
      default: ;
    endcase
  end

  // an accepted size write blocks the input in its own cycle too
  assign busy = (state != oahs_pkg::S_IDLE) || cmd.clr_start;

  // accepted item always enters a probe or slot step
  a_accept_enters_work: assert property (@(posedge clk) disable iff (rst)
    cmd.accept |=> (state == oahs_pkg::S_PROBE || state == oahs_pkg::S_SLOT))
    else $error("accepted item did not start work");

  // a result frees the block for the next item
  a_emit_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && !cmd.clr_start) |=> state == oahs_pkg::S_IDLE)
    else $error("block not idle after result");

  // no table update or result during the clearing pass
  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    (state == oahs_pkg::S_CLEAR) |->
      !(cmd.wr_insert || cmd.wr_delete || cmd.wr_value || cmd.emit || cmd.accept))
    else $error("activity during clearing pass");

endmodule

// File: rtl/oahs_dp.sv
// ----------------------------------------------------------------------------
// oahs_dp
// Datapath of the hash set: slot memories, probe address, counters, result.
// ----------------------------------------------------------------------------
module oahs_dp #(
  parameter int SLOTS_LOG2 = oahs_pkg::SLOTS_LOG2_DEFAULT,
  parameter int VALUE_BITS = oahs_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  oahs_pkg::ctrl_cmd_t           cmd,
  input  logic [oahs_pkg::TSL_W-1:0]    cfg_wr_data,
  input  oahs_pkg::item_t               item,
  output oahs_pkg::ctrl_status_t        sts,
  output logic                          done,
  output oahs_pkg::result_t             result
);

  localparam int DEPTH = 1 << SLOTS_LOG2;
  localparam int AW    = SLOTS_LOG2;
  localparam int SW    = SLOTS_LOG2 + 1;
  localparam int CMPW  = (SW > oahs_pkg::SLOT_W) ? SW : oahs_pkg::SLOT_W;

  // control registers
  logic [oahs_pkg::TSL_W-1:0] tsl;
  logic [SW-1:0]              live;
  logic [SW-1:0]              live_next;
  logic [AW-1:0]              clr_cnt;

  // per-item registers
  oahs_pkg::op_t                op_r;
  logic [oahs_pkg::KEY_W-1:0]   key_r;
  logic [oahs_pkg::SLOT_W-1:0]  slot_r;
  logic [VALUE_BITS-1:0]        vin_r;
  logic [AW-1:0]                cur_addr;
  logic [AW-1:0]                addr_next;
  logic [AW-1:0]                probe_cnt;
  logic                         have_tomb;
  logic [AW-1:0]                tomb_at;
  oahs_pkg::result_t            res_next;

  // derived values
  logic [AW-1:0]              mask;
  logic [SW-1:0]              size;
  logic [AW-1:0]              step;
  logic [oahs_pkg::TSL_W-1:0] tsl_sat;
  logic [AW-1:0]              target;
  logic                       is_tomb;

  // memory ports
  logic                         st_we;
  logic [AW-1:0]                st_waddr;
  logic [1:0]                   st_wdata;
  logic [1:0]                   st_rdata;
  logic [oahs_pkg::KEY_W-1:0]   key_rdata;
  logic                         val_we;
  logic [AW-1:0]                val_waddr;
  logic [VALUE_BITS-1:0]        val_wdata;
  logic [VALUE_BITS-1:0]        val_rdata;

  // table geometry from the size register
  assign mask = ~({AW{1'b1}} << tsl);
  assign size = SW'(1) << tsl;
  assign step = AW'((key_r >> 2) | oahs_pkg::STEP_OR);

  // size write saturates into the supported range
  always_comb begin
    tsl_sat = cfg_wr_data;
    if (cfg_wr_data < oahs_pkg::TSL_MIN) begin
      tsl_sat = oahs_pkg::TSL_MIN;
    end else if (32'(cfg_wr_data) > SLOTS_LOG2) begin
      tsl_sat = oahs_pkg::TSL_W'(SLOTS_LOG2);
    end
  end

  // read address: first probe or slot at accept, then stepped probes
  always_comb begin
    addr_next = cur_addr;
    if (cmd.accept) begin
      if (item.op == oahs_pkg::OP_DELETE || item.op == oahs_pkg::OP_WRITE) begin
        addr_next = AW'(item.slot);
      end else begin
        addr_next = AW'(item.key) & mask;
      end
    end else if (cmd.probe_next) begin
      addr_next = (cur_addr + step) & mask;
    end
  end

  // first tombstone of the probe, current slot included
  assign is_tomb = (st_rdata == oahs_pkg::SLOT_TOMB);
  assign target  = have_tomb ? tomb_at : cur_addr;

  // live entry count
  always_comb begin
    live_next = live;
    if (cmd.wr_insert) begin
      live_next = live + SW'(1);
    end else if (cmd.wr_delete) begin
      live_next = live - SW'(1);
    end
  end

  // status toward the controller
  always_comb begin
    sts.op         = op_r;
    sts.item_op    = item.op;
    sts.rd_state   = oahs_pkg::slot_state_t'(st_rdata);
    sts.key_match  = (key_rdata == key_r);
    sts.probe_last = (probe_cnt == mask);
    sts.over_half  = ({live, 1'b0} > (SW + 1)'(size));
    sts.have_tomb  = have_tomb || is_tomb;
    sts.slot_ok    = (CMPW'(slot_r) < CMPW'(size));
    sts.clr_last   = (clr_cnt == {AW{1'b1}});
    sts.live_zero  = (live == '0);
  end

  // slot state memory writes: clearing pass, insert, delete
  always_comb begin
    st_we    = cmd.clr_step || cmd.wr_insert || cmd.wr_delete;
    st_waddr = cur_addr;
    st_wdata = oahs_pkg::SLOT_TOMB;
    if (cmd.clr_step) begin
      st_waddr = clr_cnt;
      st_wdata = oahs_pkg::SLOT_EMPTY;
    end else if (cmd.wr_insert) begin
      st_waddr = target;
      st_wdata = oahs_pkg::SLOT_LIVE;
    end
  end

  // value memory writes: zero on insert, caller value on write
  always_comb begin
    val_we    = cmd.wr_insert || cmd.wr_value;
    val_waddr = cmd.wr_insert ? target : cur_addr;
    val_wdata = cmd.wr_insert ? '0 : vin_r;
  end

  // result beat
  always_comb begin
    res_next.status      = cmd.res_status;
    res_next.slot_out    = '0;
    res_next.value_out   = '0;
    res_next.entry_count = oahs_pkg::COUNT_W'(live_next);
    case (cmd.res_status)
      oahs_pkg::ST_FOUND: begin
        res_next.slot_out  = oahs_pkg::SLOT_W'(cur_addr);
        res_next.value_out = oahs_pkg::DATA_W'(val_rdata);
      end
      oahs_pkg::ST_INSERTED: begin
        res_next.slot_out = oahs_pkg::SLOT_W'(target);
      end
      oahs_pkg::ST_DONE: begin
        res_next.slot_out  = oahs_pkg::SLOT_W'(cur_addr);
        res_next.value_out = (op_r == oahs_pkg::OP_DELETE) ?
                             oahs_pkg::DATA_W'(val_rdata) : oahs_pkg::DATA_W'(vin_r);
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      tsl     <= oahs_pkg::TSL_RESET;
      live    <= '0;
      clr_cnt <= '0;
      done    <= 1'b0;
    end else begin
      if (cmd.clr_start) begin
        tsl     <= tsl_sat;
        clr_cnt <= '0;
      end else if (cmd.clr_step) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
      live <= live_next;
      done <= cmd.emit;
    end
  end

  // item and probe registers
  always_ff @(posedge clk) begin
    cur_addr <= addr_next;
    if (cmd.accept) begin
      op_r      <= item.op;
      key_r     <= item.key;
      slot_r    <= item.slot;
      vin_r     <= VALUE_BITS'(item.value_in);
      probe_cnt <= '0;
      have_tomb <= 1'b0;
    end else if (cmd.probe_next) begin
      probe_cnt <= probe_cnt + AW'(1);
      if (is_tomb && !have_tomb) begin
        have_tomb <= 1'b1;
        tomb_at   <= cur_addr;
      end
    end
    if (cmd.emit) begin
      result <= res_next;
    end
  end

  // slot state, key and value stores
  oahs_ram #(.WIDTH(2), .DEPTH(DEPTH)) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (addr_next),
    .rdata (st_rdata)
  );

  oahs_ram #(.WIDTH(oahs_pkg::KEY_W), .DEPTH(DEPTH)) u_key_ram (
    .clk   (clk),
    .we    (cmd.wr_insert),
    .waddr (target),
    .wdata (key_r),
    .raddr (addr_next),
    .rdata (key_rdata)
  );

  oahs_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_value_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (val_wdata),
    .raddr (addr_next),
    .rdata (val_rdata)
  );

  // an insert adds exactly one live entry
  a_insert_counts: assert property (@(posedge clk) disable iff (rst)
    cmd.wr_insert |=> live == $past(live) + 1'b1)
    else $error("live count not bumped by insert");

  // result strobe only follows an emit command
  a_done_from_emit: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(cmd.emit))
    else $error("result strobe without emit");

  // accepted size write restarts the clearing sweep at slot zero
  a_clear_restart: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_start |=> clr_cnt == '0)
    else $error("clearing sweep not restarted");

endmodule

// File: rtl/open_addressing_hash_set.sv
// ----------------------------------------------------------------------------
// open_addressing_hash_set
// Hash set of 32-bit keys with one value each, open addressing, tombstones.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its result appears on
// result for exactly one cycle with done high, and must be taken then. Lookup
// and get-or-insert probe k slots, one read of the slot memories per cycle, k
// being at most the table size in use, before the next item can be accepted;
// delete and write-value work on the given slot alone. After reset, and after
// every accepted table-size write, a clearing pass empties all 2^SLOTS_LOG2
// slots, one per cycle, with busy high (from the write cycle itself on). The
// size write takes effect only while the table holds no live entries.
module open_addressing_hash_set #(
  parameter int SLOTS_LOG2 = oahs_pkg::SLOTS_LOG2_DEFAULT,
  parameter int VALUE_BITS = oahs_pkg::VALUE_BITS_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  oahs_pkg::item_t            item,
  input  logic                       cfg_wr_en,
  input  logic [oahs_pkg::TSL_W-1:0] cfg_wr_data,
  output logic                       done,
  output oahs_pkg::result_t          result
);

  oahs_pkg::ctrl_cmd_t    cmd;
  oahs_pkg::ctrl_status_t sts;

  // sequencer
  oahs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cfg_wr_en (cfg_wr_en),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy)
  );

  // tables and probe datapath
  oahs_dp #(
    .SLOTS_LOG2 (SLOTS_LOG2),
    .VALUE_BITS (VALUE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_wr_data (cfg_wr_data),
    .item        (item),
    .sts         (sts),
    .done        (done),
    .result      (result)
  );

endmodule
